### rtl/core/c_style_token_scanner_top_macros.svh
// ----------------------------------------------------------------------------
// Token scanner assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef C_STYLE_TOKEN_SCANNER_TOP_MACROS_SVH
`define C_STYLE_TOKEN_SCANNER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CTS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/cts_pkg.sv
// ----------------------------------------------------------------------------
// Token scanner package
// Payload types, token kinds, operator and delimiter codes, and the
// character classification helpers shared by the scanner modules.
// ----------------------------------------------------------------------------
package cts_pkg;

   typedef enum logic [2:0] {
      KIND_WORD  = 3'd0,
      KIND_INT   = 3'd1,
      KIND_OP    = 3'd2,
      KIND_DELIM = 3'd3,
      KIND_END   = 3'd4,
      KIND_ERROR = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_WORD = 2'd1,
      MODE_INT  = 2'd2,
      MODE_OP   = 2'd3
   } mode_type;

   // Operator and delimiter codes
   localparam logic [5:0] CODE_PLAIN    = 6'd0;
   localparam logic [5:0] CODE_STAR_EQ  = 6'd0;
   localparam logic [5:0] CODE_STAR     = 6'd1;
   localparam logic [5:0] CODE_SLASH_EQ = 6'd2;
   localparam logic [5:0] CODE_SLASH    = 6'd3;
   localparam logic [5:0] CODE_PCT_EQ   = 6'd4;
   localparam logic [5:0] CODE_PCT      = 6'd5;
   localparam logic [5:0] CODE_INC      = 6'd6;
   localparam logic [5:0] CODE_PLUS_EQ  = 6'd7;
   localparam logic [5:0] CODE_PLUS     = 6'd8;
   localparam logic [5:0] CODE_DEC      = 6'd9;
   localparam logic [5:0] CODE_MINUS_EQ = 6'd10;
   localparam logic [5:0] CODE_ARROW    = 6'd11;
   localparam logic [5:0] CODE_MINUS    = 6'd12;
   localparam logic [5:0] CODE_EQ_EQ    = 6'd13;
   localparam logic [5:0] CODE_ASSIGN   = 6'd14;
   localparam logic [5:0] CODE_GT_EQ    = 6'd15;
   localparam logic [5:0] CODE_SHR      = 6'd16;
   localparam logic [5:0] CODE_GT       = 6'd17;
   localparam logic [5:0] CODE_LT_EQ    = 6'd18;
   localparam logic [5:0] CODE_SHL      = 6'd19;
   localparam logic [5:0] CODE_LT       = 6'd20;
   localparam logic [5:0] CODE_NOT_EQ   = 6'd21;
   localparam logic [5:0] CODE_NOT      = 6'd22;
   localparam logic [5:0] CODE_LOG_AND  = 6'd23;
   localparam logic [5:0] CODE_AND      = 6'd24;
   localparam logic [5:0] CODE_LOG_OR   = 6'd25;
   localparam logic [5:0] CODE_OR       = 6'd26;
   localparam logic [5:0] CODE_TILDE    = 6'd27;
   localparam logic [5:0] CODE_CARET    = 6'd28;
   localparam logic [5:0] CODE_QUEST    = 6'd29;
   localparam logic [5:0] CODE_COLON    = 6'd30;
   localparam logic [5:0] CODE_DOT      = 6'd31;
   localparam logic [5:0] CODE_LPAREN   = 6'd32;
   localparam logic [5:0] CODE_LBRACE   = 6'd33;
   localparam logic [5:0] CODE_LBRACK   = 6'd34;
   localparam logic [5:0] CODE_RPAREN   = 6'd35;
   localparam logic [5:0] CODE_RBRACE   = 6'd36;
   localparam logic [5:0] CODE_RBRACK   = 6'd37;
   localparam logic [5:0] CODE_SEMI     = 6'd38;
   localparam logic [5:0] CODE_COMMA    = 6'd39;
   localparam logic [5:0] CODE_SCOPE    = 6'd40;

   localparam logic [15:0] POS_MAX = 16'hFFFF;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_of_text;
   } req_payload_type;

   typedef struct packed {
      kind_type    token_kind;
      logic [5:0]  token_code;
      logic [15:0] start_line;
      logic [15:0] start_col;
      logic [7:0]  token_len;
      logic        last;
   } rsp_payload_type;

   typedef struct packed {
      mode_type    mode;
      logic [7:0]  pending_char;
      logic [15:0] tok_line;
      logic [15:0] tok_col;
      logic [7:0]  tok_len;
      logic [15:0] cur_line;
      logic [15:0] cur_col;
      logic        ended;
   } scan_state_type;

   // Result of one scan step: up to two tokens plus the state to keep
   typedef struct packed {
      logic [1:0]      count;
      rsp_payload_type r0;
      rsp_payload_type r1;
      scan_state_type  next;
   } step_out_type;

   typedef struct packed {
      logic       hit;
      logic [5:0] code;
   } code_hit_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == " " || c == 8'h09 || c == 8'h0A;
   endfunction

   function automatic logic is_pairable(input logic [7:0] c);
      return c == "*" || c == "/" || c == "%" || c == "+" || c == "-" || c == "=" ||
             c == ">" || c == "<" || c == "!" || c == "&" || c == "|" || c == ":";
   endfunction

   // Code of an operator character left alone
   function automatic logic [5:0] single_code(input logic [7:0] p);
      logic [5:0] code;
      case (p)
         "*":     code = CODE_STAR;
         "/":     code = CODE_SLASH;
         "%":     code = CODE_PCT;
         "+":     code = CODE_PLUS;
         "-":     code = CODE_MINUS;
         "=":     code = CODE_ASSIGN;
         ">":     code = CODE_GT;
         "<":     code = CODE_LT;
         "!":     code = CODE_NOT;
         "&":     code = CODE_AND;
         "|":     code = CODE_OR;
         default: code = CODE_COLON;
      endcase
      return code;
   endfunction

   // Two-character operator made of p then c
   function automatic code_hit_type pair_code(input logic [7:0] p, input logic [7:0] c);
      code_hit_type r;
      r = '{hit: 1'b0, code: CODE_PLAIN};
      case (p)
         "*": if (c == "=") r = '{1'b1, CODE_STAR_EQ};
         "/": if (c == "=") r = '{1'b1, CODE_SLASH_EQ};
         "%": if (c == "=") r = '{1'b1, CODE_PCT_EQ};
         "+": begin
            if (c == "+") r = '{1'b1, CODE_INC};
            else if (c == "=") r = '{1'b1, CODE_PLUS_EQ};
         end
         "-": begin
            if (c == "-") r = '{1'b1, CODE_DEC};
            else if (c == "=") r = '{1'b1, CODE_MINUS_EQ};
            else if (c == ">") r = '{1'b1, CODE_ARROW};
         end
         "=": if (c == "=") r = '{1'b1, CODE_EQ_EQ};
         ">": begin
            if (c == "=") r = '{1'b1, CODE_GT_EQ};
            else if (c == ">") r = '{1'b1, CODE_SHR};
         end
         "<": begin
            if (c == "=") r = '{1'b1, CODE_LT_EQ};
            else if (c == "<") r = '{1'b1, CODE_SHL};
         end
         "!": if (c == "=") r = '{1'b1, CODE_NOT_EQ};
         "&": if (c == "&") r = '{1'b1, CODE_LOG_AND};
         "|": if (c == "|") r = '{1'b1, CODE_LOG_OR};
         ":": if (c == ":") r = '{1'b1, CODE_SCOPE};
         default: r = '{hit: 1'b0, code: CODE_PLAIN};
      endcase
      return r;
   endfunction

   // Operators that never combine with a following character
   function automatic code_hit_type solo_code(input logic [7:0] c);
      code_hit_type r;
      case (c)
         "~":     r = '{1'b1, CODE_TILDE};
         "^":     r = '{1'b1, CODE_CARET};
         "?":     r = '{1'b1, CODE_QUEST};
         ".":     r = '{1'b1, CODE_DOT};
         default: r = '{1'b0, CODE_PLAIN};
      endcase
      return r;
   endfunction

   function automatic code_hit_type delim_code(input logic [7:0] c);
      code_hit_type r;
      case (c)
         "(":     r = '{1'b1, CODE_LPAREN};
         "{":     r = '{1'b1, CODE_LBRACE};
         "[":     r = '{1'b1, CODE_LBRACK};
         ")":     r = '{1'b1, CODE_RPAREN};
         "}":     r = '{1'b1, CODE_RBRACE};
         "]":     r = '{1'b1, CODE_RBRACK};
         ";":     r = '{1'b1, CODE_SEMI};
         ",":     r = '{1'b1, CODE_COMMA};
         default: r = '{1'b0, CODE_PLAIN};
      endcase
      return r;
   endfunction

endpackage

### rtl/core/cts_stream_if.sv
// ----------------------------------------------------------------------------
// Token scanner stream channel
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface cts_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/cts_step.sv
// ----------------------------------------------------------------------------
// Token scanner step logic
// Combinational next state and up to two tokens for one character.
// ----------------------------------------------------------------------------
module cts_step
   import cts_pkg::*;
#(
   parameter logic [7:0] LEN_CAP = 8'd255
) (
   input  scan_state_type  state,
   input  req_payload_type item,
   output step_out_type    result
);

   logic [7:0]      c;
   logic            eot;
   rsp_payload_type flush_tok;
   rsp_payload_type begin_tok;
   rsp_payload_type pair_tok;
   rsp_payload_type end_tok;
   logic            begin_emit;
   scan_state_type  begin_state;
   code_hit_type    pair_hit;
   code_hit_type    solo_hit;
   code_hit_type    delim_hit;
   logic [7:0]      len_inc;
   scan_state_type  nxt;
   logic [1:0]      count;
   rsp_payload_type r0;
   rsp_payload_type r1;

   assign c   = item.ch;
   assign eot = item.end_of_text || (item.ch == 8'd0);

   assign pair_hit  = pair_code(state.pending_char, c);
   assign solo_hit  = solo_code(c);
   assign delim_hit = delim_code(c);
   assign len_inc   = (state.tok_len < LEN_CAP) ? state.tok_len + 8'd1 : state.tok_len;

   // Token left pending by the current mode
   always_comb begin
      flush_tok = '{token_kind: KIND_WORD, token_code: CODE_PLAIN,
                    start_line: state.tok_line, start_col: state.tok_col,
                    token_len: state.tok_len, last: 1'b0};
      case (state.mode)
         MODE_INT: flush_tok.token_kind = KIND_INT;
         MODE_OP: begin
            flush_tok.token_kind = KIND_OP;
            flush_tok.token_code = single_code(state.pending_char);
            flush_tok.token_len  = 8'd1;
         end
         default: flush_tok.token_kind = KIND_WORD;
      endcase
   end

   // Character seen with no token pending
   always_comb begin
      begin_state      = state;
      begin_state.mode = MODE_IDLE;
      begin_emit       = 1'b0;
      begin_tok = '{token_kind: KIND_ERROR, token_code: CODE_PLAIN,
                    start_line: state.cur_line, start_col: state.cur_col,
                    token_len: 8'd1, last: 1'b0};
      if (is_space(c)) begin
         begin_emit = 1'b0;
      end else if (is_alpha(c) || is_digit(c) || is_pairable(c)) begin
         begin_state.mode     = is_alpha(c) ? MODE_WORD : (is_digit(c) ? MODE_INT : MODE_OP);
         begin_state.tok_line = state.cur_line;
         begin_state.tok_col  = state.cur_col;
         begin_state.tok_len  = 8'd1;
         if (is_pairable(c)) begin
            begin_state.pending_char = c;
         end
      end else if (solo_hit.hit) begin
         begin_emit           = 1'b1;
         begin_tok.token_kind = KIND_OP;
         begin_tok.token_code = solo_hit.code;
      end else if (delim_hit.hit) begin
         begin_emit           = 1'b1;
         begin_tok.token_kind = KIND_DELIM;
         begin_tok.token_code = delim_hit.code;
      end else begin
         begin_emit = 1'b1;
      end
   end

   assign pair_tok = '{token_kind: (pair_hit.code == CODE_SCOPE) ? KIND_DELIM : KIND_OP,
                       token_code: pair_hit.code, start_line: state.tok_line,
                       start_col: state.tok_col, token_len: 8'd2, last: 1'b0};

   assign end_tok = '{token_kind: KIND_END, token_code: CODE_PLAIN,
                      start_line: state.cur_line,
                      start_col: (state.cur_col == POS_MAX) ? POS_MAX : state.cur_col + 16'd1,
                      token_len: 8'd0, last: 1'b0};

   always_comb begin
      nxt   = state;
      count = 2'd0;
      r0    = flush_tok;
      r1    = end_tok;
      if (state.ended) begin
         count = 2'd0;
      end else if (eot) begin
         nxt.mode  = MODE_IDLE;
         nxt.ended = 1'b1;
         if (state.mode != MODE_IDLE) begin
            count = 2'd2;
         end else begin
            r0    = end_tok;
            count = 2'd1;
         end
      end else if ((state.mode == MODE_WORD && (is_alpha(c) || is_digit(c))) ||
                   (state.mode == MODE_INT && is_digit(c))) begin
         nxt.tok_len = len_inc;
      end else if (state.mode == MODE_OP && pair_hit.hit) begin
         nxt.mode = MODE_IDLE;
         r0       = pair_tok;
         count    = 2'd1;
      end else if (state.mode != MODE_IDLE) begin
         nxt   = begin_state;
         r1    = begin_tok;
         count = begin_emit ? 2'd2 : 2'd1;
      end else begin
         nxt   = begin_state;
         r0    = begin_tok;
         count = begin_emit ? 2'd1 : 2'd0;
      end

      // Advance the position past this character
      if (!state.ended && !eot) begin
         if (c == 8'h0A) begin
            nxt.cur_line = (state.cur_line == POS_MAX) ? POS_MAX : state.cur_line + 16'd1;
            nxt.cur_col  = 16'd0;
         end else if (state.cur_col != POS_MAX) begin
            nxt.cur_col = state.cur_col + 16'd1;
         end
      end

      r0.last = (count == 2'd1);
      r1.last = 1'b1;
   end

   assign result = '{count: count, r0: r0, r1: r1, next: nxt};

endmodule

### rtl/core/c_style_token_scanner_top.sv
// ----------------------------------------------------------------------------
// C-style token scanner
// Turns a character stream into word, integer, operator, delimiter,
// end and error tokens with start position and length.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one source character per item (ch, end_of_text); a
//   zero ch or end_of_text set ends the text. rsp_chan carries tokens, with
//   last set on the final token caused by an input item.
//   An item is registered in the input register at acceptance and scanned
//   from there; its tokens are registered in the output register, from
//   which rsp_chan offers the first token of the item.
//   Throughput is one character per cycle while rsp_chan takes tokens. A
//   character that closes one token and opens another (or the end of text
//   after a pending token) gives two tokens; the second uses a spill
//   register, and a next character with tokens waits while it drains.
//   Characters that give no token are scanned even while rsp_chan stalls.
//   When the receiver stalls, the output and spill registers hold their
//   tokens and the input register holds its character; req_chan.ready then
//   stays low while that character has tokens that find no room.
//   After the end of text every further item is accepted and dropped until
//   reset. Synchronous reset clears position, mode and all valid flags.
// ----------------------------------------------------------------------------
module c_style_token_scanner_top
   import cts_pkg::*;
#(
   parameter int MAX_TOKEN_LEN = 255
) (
   input  logic        clock,
   input  logic        reset,
   cts_stream_if.sink   req_chan,
   cts_stream_if.source rsp_chan
);

`include "c_style_token_scanner_top_macros.svh"

   // Length saturates at the parameter and at the 8-bit field limit
   localparam logic [7:0] LenCap = (MAX_TOKEN_LEN > 255) ? 8'd255 : 8'(MAX_TOKEN_LEN);

   localparam scan_state_type StateReset = '{
      mode: MODE_IDLE, pending_char: 8'd0, tok_line: 16'd0, tok_col: 16'd0,
      tok_len: 8'd0, cur_line: 16'd0, cur_col: 16'd0, ended: 1'b0};

   // Input register
   logic            in_valid_ff;
   logic            in_valid_in;
   req_payload_type in_data_ff;

   // Scanner state
   scan_state_type  state_ff;
   scan_state_type  state_in;

   // Output register and spill register for the second token of an item
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_payload_type out_ff;
   rsp_payload_type out_in;
   logic            spill_valid_ff;
   logic            spill_valid_in;
   rsp_payload_type spill_ff;
   rsp_payload_type spill_in;

   step_out_type    step;
   logic            take;
   logic            can_place;
   logic            scan_go;
   logic            accept;

   cts_step #(
      .LEN_CAP (LenCap)
   ) u_step (
      .state  (state_ff),
      .item   (in_data_ff),
      .result (step)
   );

   // Handshake: scan the held character once its tokens have room
   assign take      = out_valid_ff && rsp_chan.ready;
   assign can_place = !spill_valid_ff && (!out_valid_ff || take);
   assign scan_go   = in_valid_ff && ((step.count == 2'd0) || can_place);
   assign accept    = req_chan.valid && req_chan.ready;

   assign req_chan.ready   = !in_valid_ff || scan_go;
   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;

   assign in_valid_in = accept || (in_valid_ff && !scan_go);
   assign state_in    = scan_go ? step.next : state_ff;

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_in         = out_ff;
      spill_valid_in = spill_valid_ff;
      spill_in       = spill_ff;
      if (spill_valid_ff) begin
         // Drain the spill first; no new tokens enter meanwhile
         if (take) begin
            out_in         = spill_ff;
            spill_valid_in = 1'b0;
         end
      end else if (scan_go && step.count != 2'd0) begin
         out_valid_in = 1'b1;
         out_in       = step.r0;
         if (step.count == 2'd2) begin
            spill_valid_in = 1'b1;
            spill_in       = step.r1;
         end
      end else if (take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         state_ff       <= StateReset;
         out_valid_ff   <= 1'b0;
         spill_valid_ff <= 1'b0;
      end else begin
         in_valid_ff    <= in_valid_in;
         state_ff       <= state_in;
         out_valid_ff   <= out_valid_in;
         spill_valid_ff <= spill_valid_in;
      end
   end

   // Payload registers: no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         in_data_ff <= req_chan.payload;
      end
      out_ff   <= out_in;
      spill_ff <= spill_in;
   end

   // A spilled token always sits behind a token in the output register
   `CTS_ASSERT_IMPLY(a_spill_behind_out, clock, reset, spill_valid_ff, out_valid_ff, "spill without output token")

   // Nothing new may enter while the spill still holds a token
   `CTS_ASSERT_IMPLY(a_no_load_over_spill, clock, reset, spill_valid_ff && scan_go, step.count == 2'd0, "token loaded while spill busy")

   // Once the end token is produced, the scanner stays ended and silent
   `CTS_ASSERT_NEXT(a_ended_sticks, clock, reset, state_ff.ended, state_ff.ended && !(scan_go && step.count != 2'd0), "scanner left ended state")

endmodule
